FILE: src/bpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, constants and the divider step for the pressure compensation.
// ----------------------------------------------------------------------------
package bpc_pkg;

   // compensation constants
   localparam int unsigned FINE_OFFSET = 128000;
   localparam int unsigned PRESS_FULL  = 1048576;
   localparam int unsigned PRESS_SCALE = 3125;
   localparam int unsigned ONE_SHIFT   = 47;
   localparam int unsigned P1_SHIFT    = 33;
   localparam int unsigned TEMP_ROUND  = 128;

   // register file
   localparam int unsigned REG_COUNT   = 4;
   localparam int unsigned REG_WIDTH   = 48;
   localparam int unsigned CSR_ADDR_W  = 5;
   localparam int unsigned CSR_DATA_W  = 64;
   localparam int unsigned REG_SEL_LSB = 3;

   // divider: quotient bits resolved per stage
   localparam int unsigned DIV_STEPS   = 2;
   localparam int unsigned DIV_STAGES  = 64 / DIV_STEPS;

   typedef enum logic [1:0] {
      REG_TEMP    = 2'd0,
      REG_PRESS_A = 2'd1,
      REG_PRESS_B = 2'd2,
      REG_PRESS_C = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [19:0] raw_pressure;
   } req_type;

   typedef struct packed {
      logic [31:0]        pressure_q24_8;
      logic signed [31:0] temperature_centi;
      logic               pressure_valid;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic [15:0]        p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } coef_type;

   // per-item control that rides along the pipeline
   typedef struct packed {
      logic               valid;
      logic               nonzero;
      logic signed [31:0] temp;
   } tag_type;

   typedef struct packed {
      logic               valid;
      logic signed [23:0] fine;
      logic [19:0]        raw_pressure;
   } fine_type;

   typedef struct packed {
      tag_type            tag;
      logic [63:0]        num;
      logic signed [30:0] den;
   } num_type;

   typedef struct packed {
      tag_type     tag;
      logic [63:0] mag;
      logic        neg;
   } quot_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [63:0] work;
   } div_acc_type;

   typedef struct packed {
      tag_type     tag;
      div_acc_type acc;
      logic [30:0] divisor;
      logic        neg;
   } div_pipe_type;

   // one restoring division step: dividend bits leave the top of work,
   // quotient bits enter at the bottom
   function automatic div_acc_type div_step(div_acc_type acc, logic [30:0] divisor);
      logic [31:0] trial;
      div_acc_type nxt;
      trial    = {acc.rem[30:0], acc.work[63]};
      nxt.work = {acc.work[62:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
         nxt.rem     = trial - {1'b0, divisor};
         nxt.work[0] = 1'b1;
      end else begin
         nxt.rem = trial;
      end
      return nxt;
   endfunction

endpackage

FILE: src/bpc_temp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_temp
// Three-stage fine temperature pipeline.
// ----------------------------------------------------------------------------
module bpc_temp (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  bpc_pkg::req_type  in_item,
   input  bpc_pkg::coef_type coef,
   output bpc_pkg::fine_type out_fine
);
   import bpc_pkg::*;

   logic signed [19:0] d1;
   logic signed [19:0] d2;
   logic signed [35:0] m1_in, m1_ff;
   logic signed [39:0] m2_in, m2_ff;
   logic signed [24:0] a_in, a_ff;
   logic signed [43:0] m3_in, m3_ff;
   logic [27:0]        b0;
   logic [31:0]        fine_sum;
   logic [19:0]        press1_ff, press2_ff;
   logic               valid1_ff, valid2_ff;
   fine_type           fine_in, fine_ff;

   // stage 1
   assign d1    = $signed({3'b000, in_item.raw_temperature[19:3]})
                - $signed({3'b000, coef.t1, 1'b0});
   assign d2    = $signed({4'b0000, in_item.raw_temperature[19:4]})
                - $signed({4'b0000, coef.t1});
   assign m1_in = d1 * coef.t2;
   assign m2_in = d2 * d2;

   // stage 2
   assign a_in  = m1_ff[35:11];
   assign b0    = m2_ff[39:12];
   assign m3_in = $signed({1'b0, b0}) * coef.t3;

   // stage 3
   assign fine_sum = {{7{a_ff[24]}}, a_ff} + {{2{m3_ff[43]}}, m3_ff[43:14]};
   always_comb begin
      fine_in.valid        = valid2_ff;
      fine_in.fine         = fine_sum[23:0];
      fine_in.raw_pressure = press2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff     <= 1'b0;
         valid2_ff     <= 1'b0;
         fine_ff.valid <= 1'b0;
      end else if (advance) begin
         valid1_ff     <= in_valid;
         valid2_ff     <= valid1_ff;
         fine_ff.valid <= fine_in.valid;
      end
      if (advance) begin
         m1_ff                <= m1_in;
         m2_ff                <= m2_in;
         press1_ff            <= in_item.raw_pressure;
         a_ff                 <= a_in;
         m3_ff                <= m3_in;
         press2_ff            <= press1_ff;
         fine_ff.fine         <= fine_in.fine;
         fine_ff.raw_pressure <= fine_in.raw_pressure;
      end
   end

   assign out_fine = fine_ff;

endmodule

FILE: src/bpc_comp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_comp
// Five-stage pipeline forming the division operands and the temperature.
// ----------------------------------------------------------------------------
module bpc_comp (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  bpc_pkg::fine_type in_fine,
   input  bpc_pkg::coef_type coef,
   output bpc_pkg::num_type  out_num
);
   import bpc_pkg::*;

   localparam int unsigned NSTAGE = 5;

   tag_type            tag_in [NSTAGE];
   tag_type            tag_ff [NSTAGE];

   logic signed [23:0] v1_in, v1_ff;
   logic signed [26:0] f27;
   logic signed [26:0] five;
   logic signed [47:0] sq_in, sq_ff;
   logic [20:0]        d_in, d1_ff, d2_ff, d3_ff;
   logic signed [63:0] x6_in, x6_ff;
   logic signed [63:0] x3_in, x3_ff;
   logic signed [39:0] m5_in, m5_ff;
   logic signed [39:0] m2_in, m2_ff;
   logic [63:0]        v2_in, v2_ff;
   logic [63:0]        v1a_in, v1a_ff;
   logic [63:0]        pre;
   logic [43:0]        pl_in, pl_ff;
   logic [31:0]        ph_in, ph_ff;
   logic [47:0]        yl_in, yl_ff;
   logic [31:0]        yh_in, yh_ff;
   logic [63:0]        y;
   logic [63:0]        num_in, num_ff;
   logic signed [30:0] den_in, den_ff;

   // stage 1: offset fine term, temperature, square
   assign v1_in = in_fine.fine - 24'(FINE_OFFSET);
   assign f27   = {{3{in_fine.fine[23]}}, in_fine.fine};
   assign five  = (f27 <<< 2) + f27 + 27'(TEMP_ROUND);
   assign sq_in = v1_in * v1_in;
   assign d_in  = 21'(PRESS_FULL) - {1'b0, in_fine.raw_pressure};

   // stage 2: coefficient products
   assign x6_in = sq_ff * coef.p6;
   assign x3_in = sq_ff * coef.p3;
   assign m5_in = v1_ff * coef.p5;
   assign m2_in = v1_ff * coef.p2;

   // stage 3: sums
   assign v2_in  = x6_ff + {{7{m5_ff[39]}}, m5_ff, 17'b0}
                 + {{13{coef.p4[15]}}, coef.p4, 35'b0};
   assign v1a_in = {{8{x3_ff[63]}}, x3_ff[63:8]} + {{12{m2_ff[39]}}, m2_ff, 12'b0}
                 + (64'd1 << ONE_SHIFT);

   // stage 4: split 64-bit products
   assign pre   = {12'b0, d3_ff, 31'b0} - v2_ff;
   assign pl_in = pre[31:0] * 12'(PRESS_SCALE);
   assign ph_in = pre[63:32] * 32'(PRESS_SCALE);
   assign yl_in = v1a_ff[31:0] * coef.p1;
   assign yh_in = v1a_ff[63:32] * {16'b0, coef.p1};

   // stage 5: recombine
   assign num_in = {20'b0, pl_ff} + {ph_ff, 32'b0};
   assign y      = {16'b0, yl_ff} + {yh_ff, 32'b0};
   assign den_in = y[63:P1_SHIFT];

   always_comb begin
      tag_in[0].valid   = in_fine.valid;
      tag_in[0].nonzero = 1'b0;
      tag_in[0].temp    = {{13{five[26]}}, five[26:8]};
      for (int k = 1; k < NSTAGE; k++) begin
         tag_in[k] = tag_ff[k-1];
      end
      tag_in[NSTAGE-1].nonzero = (den_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NSTAGE; k++) begin
            tag_ff[k].valid <= 1'b0;
         end
      end else if (advance) begin
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         v1_ff  <= v1_in;
         sq_ff  <= sq_in;
         d1_ff  <= d_in;
         x6_ff  <= x6_in;
         x3_ff  <= x3_in;
         m5_ff  <= m5_in;
         m2_ff  <= m2_in;
         d2_ff  <= d1_ff;
         v2_ff  <= v2_in;
         v1a_ff <= v1a_in;
         d3_ff  <= d2_ff;
         pl_ff  <= pl_in;
         ph_ff  <= ph_in;
         yl_ff  <= yl_in;
         yh_ff  <= yh_in;
         num_ff <= num_in;
         den_ff <= den_in;
      end
   end

   always_comb begin
      out_num.tag = tag_ff[NSTAGE-1];
      out_num.num = num_ff;
      out_num.den = den_ff;
   end

endmodule

FILE: src/bpc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_div
// Pipelined signed 64 by 31 bit divider, magnitude stage then restoring steps.
// ----------------------------------------------------------------------------
module bpc_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  bpc_pkg::num_type  in_num,
   output bpc_pkg::quot_type out_quot
);
   import bpc_pkg::*;

   div_pipe_type pipe_in [DIV_STAGES+1];
   div_pipe_type pipe_ff [DIV_STAGES+1];

   always_comb begin
      // operand magnitudes and result sign
      pipe_in[0].tag      = in_num.tag;
      pipe_in[0].acc.rem  = '0;
      pipe_in[0].acc.work = in_num.num[63] ? (64'd0 - in_num.num) : in_num.num;
      pipe_in[0].divisor  = in_num.den[30] ? (31'd0 - in_num.den) : in_num.den;
      pipe_in[0].neg      = in_num.num[63] ^ in_num.den[30];
      for (int s = 0; s < DIV_STAGES; s++) begin
         pipe_in[s+1] = pipe_ff[s];
         for (int k = 0; k < DIV_STEPS; k++) begin
            pipe_in[s+1].acc = div_step(pipe_in[s+1].acc, pipe_ff[s].divisor);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= DIV_STAGES; s++) begin
            pipe_ff[s].tag.valid <= 1'b0;
         end
      end else if (advance) begin
         pipe_ff <= pipe_in;
      end
   end

   always_comb begin
      out_quot.tag = pipe_ff[DIV_STAGES].tag;
      out_quot.mag = pipe_ff[DIV_STAGES].acc.work;
      out_quot.neg = pipe_ff[DIV_STAGES].neg;
   end

endmodule

FILE: src/bpc_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_post
// Seven-stage quotient correction pipeline ending in the result register.
// ----------------------------------------------------------------------------
module bpc_post (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  bpc_pkg::quot_type in_quot,
   input  bpc_pkg::coef_type coef,
   output logic              out_valid,
   output bpc_pkg::rsp_type  out_item
);
   import bpc_pkg::*;

   localparam int unsigned NSTAGE = 7;
   localparam int unsigned NCARRY = 4;

   tag_type            tag_in [NSTAGE];
   tag_type            tag_ff [NSTAGE];
   logic [63:0]        p_in [NCARRY];
   logic [63:0]        p_ff [NCARRY];

   logic [63:0]        ps;
   logic [63:0]        ll_in, ll_ff;
   logic [31:0]        cross_in, cross_ff;
   logic signed [48:0] p8l_in, p8l_ff;
   logic [31:0]        p8h_in, p8h_ff;
   logic [63:0]        sq_in, sq_ff;
   logic [63:0]        w2sum;
   logic [63:0]        w2_in, w2_ff, w2b_ff;
   logic signed [48:0] a9_in, a9_ff;
   logic [31:0]        b9_in, b9_ff;
   logic [63:0]        w1sum;
   logic [63:0]        w1_in, w1_ff;
   logic [63:0]        pw_in, pw_ff;
   logic [63:0]        sum_in, sum_ff;
   logic [31:0]        res_in, res_ff;

   // stage 2: square of scaled pressure and p8 term, split products
   assign ps       = {{13{p_ff[0][63]}}, p_ff[0][63:13]};
   assign ll_in    = ps[31:0] * ps[31:0];
   assign cross_in = ps[31:0] * ps[63:32];
   assign p8l_in   = $signed({1'b0, p_ff[0][31:0]}) * coef.p8;
   assign p8h_in   = p_ff[0][63:32] * {{16{coef.p8[15]}}, coef.p8};

   // stage 3
   assign sq_in = ll_ff + {cross_ff[30:0], 33'b0};
   assign w2sum = {{15{p8l_ff[48]}}, p8l_ff} + {p8h_ff, 32'b0};
   assign w2_in = {{19{w2sum[63]}}, w2sum[63:19]};

   // stage 4
   assign a9_in = $signed({1'b0, sq_ff[31:0]}) * coef.p9;
   assign b9_in = sq_ff[63:32] * {{16{coef.p9[15]}}, coef.p9};

   // stage 5
   assign w1sum = {{15{a9_ff[48]}}, a9_ff} + {b9_ff, 32'b0};
   assign w1_in = {{25{w1sum[63]}}, w1sum[63:25]};
   assign pw_in = p_ff[NCARRY-1] + w2b_ff;

   // stage 6
   assign sum_in = pw_ff + w1_ff;

   // stage 7: result register, zero when the divisor was zero
   assign res_in = tag_ff[NSTAGE-2].nonzero
                 ? (sum_ff[39:8] + {{12{coef.p7[15]}}, coef.p7, 4'b0}) : '0;

   always_comb begin
      tag_in[0] = in_quot.tag;
      p_in[0]   = in_quot.neg ? (64'd0 - in_quot.mag) : in_quot.mag;
      for (int k = 1; k < NSTAGE; k++) begin
         tag_in[k] = tag_ff[k-1];
      end
      for (int k = 1; k < NCARRY; k++) begin
         p_in[k] = p_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NSTAGE; k++) begin
            tag_ff[k].valid <= 1'b0;
         end
      end else if (advance) begin
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff     <= p_in;
         ll_ff    <= ll_in;
         cross_ff <= cross_in;
         p8l_ff   <= p8l_in;
         p8h_ff   <= p8h_in;
         sq_ff    <= sq_in;
         w2_ff    <= w2_in;
         a9_ff    <= a9_in;
         b9_ff    <= b9_in;
         w2b_ff   <= w2_ff;
         w1_ff    <= w1_in;
         pw_ff    <= pw_in;
         sum_ff   <= sum_in;
         res_ff   <= res_in;
      end
   end

   assign out_valid = tag_ff[NSTAGE-1].valid;
   always_comb begin
      out_item.pressure_q24_8    = res_ff;
      out_item.temperature_centi = tag_ff[NSTAGE-1].temp;
      out_item.pressure_valid    = tag_ff[NSTAGE-1].nonzero;
   end

endmodule

FILE: src/barometric_pressure_compensation_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_top
// Pipelined 64-bit integer temperature and pressure compensation.
// ----------------------------------------------------------------------------
//  channel | ports      | direction | carries
//  --------+------------+-----------+-------------------------------------------
//  request | req_*      | in        | raw temperature and raw pressure, 20 bits
//  result  | rsp_*      | out       | pressure Q24.8, temperature 0.01 C, valid
//  control | csr_*      | in/out    | four 48-bit calibration registers, 8 apart
//
//  one transfer accepted per cycle unless the result is stalled; a request passes
//  3 temperature, 5 operand, 33 divider and 7 correction stages on its way to the
//  result, the divider resolving two quotient bits per stage
//  synchronous reset clears all stage valid bits and the calibration registers
//  a stalled result freezes every stage together, so nothing is dropped or
//  repeated; req_ready follows the output register being free or taken
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_top (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bpc_pkg::req_type                  req_payload,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bpc_pkg::rsp_type                  rsp_payload,
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bpc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [bpc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bpc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import bpc_pkg::*;

   logic [REG_WIDTH-1:0] coef_reg_ff [REG_COUNT];
   logic [1:0]           reg_sel;
   logic                 csr_write;
   logic                 advance;
   coef_type             coef;
   fine_type             fine;
   num_type              num;
   quot_type             quot;

   // ---------------- register port ----------------
   // no wait states, writes land in the access phase
   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[CSR_ADDR_W-1:REG_SEL_LSB];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = {{(CSR_DATA_W-REG_WIDTH){1'b0}}, coef_reg_ff[reg_sel]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            coef_reg_ff[i] <= '0;
         end
      end else if (csr_write) begin
         coef_reg_ff[reg_sel] <= csr_pwdata[REG_WIDTH-1:0];
      end
   end

   // unpack calibration words, first word in the low bits
   always_comb begin
      coef.t1 = coef_reg_ff[REG_TEMP][15:0];
      coef.t2 = coef_reg_ff[REG_TEMP][31:16];
      coef.t3 = coef_reg_ff[REG_TEMP][47:32];
      coef.p1 = coef_reg_ff[REG_PRESS_A][15:0];
      coef.p2 = coef_reg_ff[REG_PRESS_A][31:16];
      coef.p3 = coef_reg_ff[REG_PRESS_A][47:32];
      coef.p4 = coef_reg_ff[REG_PRESS_B][15:0];
      coef.p5 = coef_reg_ff[REG_PRESS_B][31:16];
      coef.p6 = coef_reg_ff[REG_PRESS_B][47:32];
      coef.p7 = coef_reg_ff[REG_PRESS_C][15:0];
      coef.p8 = coef_reg_ff[REG_PRESS_C][31:16];
      coef.p9 = coef_reg_ff[REG_PRESS_C][47:32];
   end

   // ---------------- pipeline ----------------
   // the whole pipe moves when the result register is empty or being taken
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // fine temperature term
   bpc_temp u_temp (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .in_item  (req_payload),
      .coef     (coef),
      .out_fine (fine)
   );

   // temperature output, dividend and divisor
   bpc_comp u_comp (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_fine (fine),
      .coef    (coef),
      .out_num (num)
   );

   // signed division truncating toward zero
   bpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_num   (num),
      .out_quot (quot)
   );

   // second-order pressure correction and result register
   bpc_post u_post (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_quot   (quot),
      .coef      (coef),
      .out_valid (rsp_valid),
      .out_item  (rsp_payload)
   );

   // ---------------- checks ----------------
   // a guarded result carries zero pressure
   a_guard_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.pressure_valid |-> rsp_payload.pressure_q24_8 == 32'd0)
      else $error("guarded result with nonzero pressure");

   // an untaken result never vanishes
   a_result_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result blocks new requests
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while pipeline stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the pressure compensation pipeline against a 64-bit integer
// predictor under random idling and stalls, across several calibration sets.
// ----------------------------------------------------------------------------
module tb;
   import bpc_pkg::*;

   localparam int LATENCY   = 48;
   localparam int MAX_CYCLE = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic        csr_pready;

   barometric_pressure_compensation_top i_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // calibration copy used by the predictor
   logic [47:0] cal_words [REG_COUNT];

   req_type pending_readings [$];
   rsp_type expected_results [$];

   int  cycle_count = 0;
   int  mismatch_count = 0;
   int  sent_count = 0;
   int  checked_count = 0;
   int  invalid_count = 0;
   bit  hold_results = 1'b0;
   int  send_gap = 0;

   function automatic logic [63:0] sext16(logic [15:0] w);
      return {{48{w[15]}}, w};
   endfunction

   function automatic logic [63:0] sra64(logic [63:0] x, int n);
      return $signed(x) >>> n;
   endfunction

   // truncating signed division on 64-bit patterns, divisor nonzero
   function automatic logic [63:0] sdiv64(logic [63:0] a, logic [63:0] b);
      logic [63:0] ma, mb, q;
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      q  = ma / mb;
      return (a[63] != b[63]) ? -q : q;
   endfunction

   function automatic rsp_type compensate(req_type r);
      logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [63:0] at, ap, d1, ta, d2, tb2, fine, v1, v2, p, ps, w1, w2, tc;
      rsp_type o;
      t1 = {48'd0, cal_words[REG_TEMP][15:0]};
      t2 = sext16(cal_words[REG_TEMP][31:16]);
      t3 = sext16(cal_words[REG_TEMP][47:32]);
      p1 = {48'd0, cal_words[REG_PRESS_A][15:0]};
      p2 = sext16(cal_words[REG_PRESS_A][31:16]);
      p3 = sext16(cal_words[REG_PRESS_A][47:32]);
      p4 = sext16(cal_words[REG_PRESS_B][15:0]);
      p5 = sext16(cal_words[REG_PRESS_B][31:16]);
      p6 = sext16(cal_words[REG_PRESS_B][47:32]);
      p7 = sext16(cal_words[REG_PRESS_C][15:0]);
      p8 = sext16(cal_words[REG_PRESS_C][31:16]);
      p9 = sext16(cal_words[REG_PRESS_C][47:32]);
      at = {44'd0, r.raw_temperature};
      ap = {44'd0, r.raw_pressure};
      d1   = (at >> 3) - (t1 << 1);
      ta   = sra64(d1 * t2, 11);
      d2   = (at >> 4) - t1;
      tb2  = sra64(sra64(d2 * d2, 12) * t3, 14);
      fine = ta + tb2;
      tc   = sra64(fine * 64'd5 + 64'(TEMP_ROUND), 8);
      o.temperature_centi = tc[31:0];
      v1 = fine - 64'(FINE_OFFSET);
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) << 17);
      v2 = v2 + (p4 << 35);
      v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
      v1 = sra64(((64'd1 << ONE_SHIFT) + v1) * p1, P1_SHIFT);
      if (v1 == 64'd0) begin
         o.pressure_q24_8 = '0;
         o.pressure_valid = 1'b0;
      end else begin
         p  = 64'(PRESS_FULL) - ap;
         p  = sdiv64(((p << 31) - v2) * 64'(PRESS_SCALE), v1);
         ps = sra64(p, 13);
         w1 = sra64(p9 * ps * ps, 25);
         w2 = sra64(p8 * p, 19);
         p  = sra64(p + w1 + w2, 8) + (p7 << 4);
         o.pressure_q24_8 = p[31:0];
         o.pressure_valid = 1'b1;
      end
      return o;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver: offers queued readings, random gaps between transfers
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_results.push_back(compensate(req_payload));
            sent_count <= sent_count + 1;
         end
         if (req_valid && !req_ready) begin
            // hold payload until the transfer completes
         end else if (send_gap > 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_readings.size() > 0) begin
            req_payload <= pending_readings.pop_front();
            req_valid   <= 1'b1;
            send_gap    <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: random stalls on the result side, compares each transfer
   always @(posedge clock) begin
      rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected result %h", rsp_payload);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_results.pop_front();
               checked_count <= checked_count + 1;
               if (!want.pressure_valid) invalid_count <= invalid_count + 1;
               if (rsp_payload !== want) begin
                  if (mismatch_count < 10)
                     $display("mismatch: pressure %h/%h temp %h/%h valid %b/%b",
                              want.pressure_q24_8, rsp_payload.pressure_q24_8,
                              want.temperature_centi, rsp_payload.temperature_centi,
                              want.pressure_valid, rsp_payload.pressure_valid);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         rsp_ready <= hold_results ? 1'b0 : (pick_gap() == 0 || $urandom_range(0, 1) == 1);
      end
   end

   always @(posedge clock) begin
      if (cycle_count > MAX_CYCLE) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[barometric_pressure_compensation_top] ERROR");
         $finish;
      end
   end

   task automatic write_register(reg_index_type idx, logic [47:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx) << REG_SEL_LSB;
      csr_pwdata  <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cal_words[idx] = value;
   endtask

   task automatic load_calibration(logic [47:0] a, logic [47:0] b,
                                   logic [47:0] c, logic [47:0] d);
      write_register(REG_TEMP, a);
      write_register(REG_PRESS_A, b);
      write_register(REG_PRESS_B, c);
      write_register(REG_PRESS_C, d);
   endtask

   // sampled away from the active edge so queue and valid updates have settled
   task automatic drain();
      do @(negedge clock);
      while (pending_readings.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic req_type random_reading();
      req_type r;
      r.raw_temperature = 20'($urandom);
      r.raw_pressure    = 20'($urandom);
      return r;
   endfunction

   // calibration close to a real sensor, slightly perturbed
   function automatic logic [47:0] jitter(logic [15:0] w0, logic [15:0] w1, logic [15:0] w2);
      return {w2 + 16'($urandom_range(0, 15)) - 16'd8,
              w1 + 16'($urandom_range(0, 15)) - 16'd8,
              w0 + 16'($urandom_range(0, 15)) - 16'd8};
   endfunction

   initial begin
      req_type r;
      for (int i = 0; i < REG_COUNT; i++) cal_words[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // all-zero calibration: divisor guard fires on every reading
      for (int i = 0; i < 4; i++) pending_readings.push_back(random_reading());
      drain();

      // typical calibration, field extremes
      load_calibration({16'd50, 16'd26435, 16'd27504}, {16'hD0D0, 16'hD5D0, 16'd36477},
                       {16'hFFF9, 16'hFF8C, 16'd2855}, {16'd15500, 16'hC0D8, 16'd6000});
      for (int k = 0; k < 20; k++) begin
         r.raw_temperature = 20'd1 << k;
         r.raw_pressure    = ~(20'd1 << k);
         pending_readings.push_back(r);
      end
      pending_readings.push_back('0);
      pending_readings.push_back('1);
      pending_readings.push_back({20'd519888, 20'd415148});
      drain();

      // extreme calibration words: wraparound paths
      load_calibration('1, {16'h8000, 16'h7FFF, 16'hFFFF}, {16'h8000, 16'h7FFF, 16'h8000},
                       {16'h7FFF, 16'h8000, 16'h7FFF});
      for (int i = 0; i < 6; i++) pending_readings.push_back(random_reading());
      pending_readings.push_back('1);
      drain();

      // random phases, mostly realistic calibration with some fully random
      for (int phase = 0; phase < 7; phase++) begin
         if (phase % 3 == 2)
            load_calibration({$urandom, 16'($urandom)}, {$urandom, 16'($urandom)},
                             {$urandom, 16'($urandom)}, {$urandom, 16'($urandom)});
         else
            load_calibration(jitter(16'd27504, 16'd26435, 16'hFC18),
                             jitter(16'd36477, 16'hD5D0, 16'd3024),
                             jitter(16'd2855, 16'd140, 16'hFFF9),
                             jitter(16'd15500, 16'hC0D8, 16'd6000));
         if (phase == 3) hold_results = 1'b1;
         for (int i = 0; i < 250; i++) pending_readings.push_back(random_reading());
         if (phase == 3) begin
            // receiver holds off so the pipeline fills and stalls its input
            repeat (300) @(posedge clock);
            hold_results = 1'b0;
         end
         drain();
      end

      $display("readings sent %0d, results checked %0d, guarded results %0d",
               sent_count, checked_count, invalid_count);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("[barometric_pressure_compensation_top] OK");
      else
         $display("[barometric_pressure_compensation_top] ERROR");
      $finish;
   end
endmodule
